@@ rtl/hsw_pkg.sv @@
package hsw_pkg;

   localparam int MAX_RECORDS = 16;

   typedef enum logic [2:0] {
      OP_REGISTER   = 3'd0,
      OP_BEAT       = 3'd1,
      OP_UNREGISTER = 3'd2,
      OP_SNAPSHOT   = 3'd3,
      OP_POLL       = 3'd4
   } op_type;

   typedef enum logic {
      CSR_WDOG_ENABLE = 1'b0,
      CSR_STALL_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SNAP_ISSUE,
      ST_SNAP_EMIT
   } state_type;

   typedef struct packed {
      logic [63:0]        seed;
      logic [63:0]        beats;
      logic signed [15:0] action;
      logic [7:0]         level;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic        strobe;
      logic        enable;
      logic [15:0] limit;
   } poll_req_type;

endpackage

@@ rtl/hsw_ram.sv @@
module hsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/hsw_poll.sv @@
module hsw_poll import hsw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  poll_req_type poll_req,
   input  logic [63:0]  total,
   output logic         fired,
   output logic         fired_next
);

   logic [63:0] prev_total_ff, prev_total_in;
   logic [15:0] stall_polls_ff, stall_polls_in;
   logic        fired_ff, fired_in;

   always_comb begin
      prev_total_in  = prev_total_ff;
      stall_polls_in = stall_polls_ff;
      fired_in       = fired_ff;
      if (poll_req.strobe) begin
         if (!poll_req.enable || (total != prev_total_ff)) begin
            prev_total_in  = total;
            stall_polls_in = '0;
         end else if (total != '0) begin
            if (stall_polls_ff != 16'hFFFF) begin
               stall_polls_in = stall_polls_ff + 16'd1;
            end
            // The comparison uses the count after this poll is added.
            if (stall_polls_in >= poll_req.limit) begin
               fired_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_total_ff  <= '0;
         stall_polls_ff <= '0;
         fired_ff       <= 1'b0;
      end else begin
         prev_total_ff  <= prev_total_in;
         stall_polls_ff <= stall_polls_in;
         fired_ff       <= fired_in;
      end
   end

   assign fired      = fired_ff;
   assign fired_next = fired_in;

   a_fired_latched: assert property (@(posedge clock) disable iff (reset)
      fired_ff |=> fired_ff)
      else $error("fired flag dropped without reset");

   a_disabled_clears: assert property (@(posedge clock) disable iff (reset)
      poll_req.strobe && !poll_req.enable |=> stall_polls_ff == '0)
      else $error("poll with watchdog disabled left a stall count");

   a_fire_needs_stall: assert property (@(posedge clock) disable iff (reset)
      !fired_ff && fired_in |-> poll_req.strobe && poll_req.enable && total != '0)
      else $error("watchdog fired outside an enabled nonzero poll");

endmodule

@@ rtl/heartbeat_slot_watchdog.sv @@
// Channel  Direction  Handshake                Payload
// req_     in         req_valid / req_ready    operation, slot, seed, action, level, max_records
// rsp_     out        rsp_valid / rsp_ready    status .. last, one beat per result
// csr_     in         csr_wr_en                csr_index, csr_wdata, no wait
//
// Register, beat, unregister, poll and unknown codes go through an accept with the
// slot RAM read, then the update and the result load.
// A snapshot is an accept, then for each record one RAM read and one load.
// A snapshot with no record to emit goes through the same steps as the single-result codes.
// The slot RAM has a single read port; one item is in work at a time.
// Reset clears the live flags, totals and watchdog state; RAM entries need no clearing.
// A stalled result holds the block in its update or emit step until rsp_ready returns.
module heartbeat_slot_watchdog import hsw_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_operation,
   input  logic [3:0]         req_slot,
   input  logic [63:0]        req_seed,
   input  logic signed [15:0] req_action,
   input  logic [7:0]         req_level,
   input  logic [4:0]         req_max_records,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_status,
   output logic [3:0]         rsp_slot_id,
   output logic [63:0]        rsp_slot_seed,
   output logic [63:0]        rsp_slot_beats,
   output logic signed [15:0] rsp_slot_action,
   output logic [7:0]         rsp_slot_level,
   output logic               rsp_record_valid,
   output logic [63:0]        rsp_total_beats,
   output logic               rsp_stall_fired,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   state_type state_ff, state_in;

   logic              wdog_en_ff;
   logic [15:0]       stall_limit_ff;

   logic [SLOTS-1:0]  live_ff, live_in;
   logic [63:0]       total_ff, total_in;

   logic [2:0]        op_ff, op_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              hit_ff, hit_in;
   logic              full_ff, full_in;
   logic [63:0]       seed_ff, seed_in;
   logic signed [15:0] action_ff, action_in;
   logic [7:0]        level_ff, level_in;
   logic [4:0]        cap_ff, cap_in;
   logic [4:0]        nrec_ff, nrec_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              snap_last_ff, snap_last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [3:0]        rsp_slot_id_ff, rsp_slot_id_in;
   logic [63:0]       rsp_slot_seed_ff, rsp_slot_seed_in;
   logic [63:0]       rsp_slot_beats_ff, rsp_slot_beats_in;
   logic signed [15:0] rsp_slot_action_ff, rsp_slot_action_in;
   logic [7:0]        rsp_slot_level_ff, rsp_slot_level_in;
   logic              rsp_record_valid_ff, rsp_record_valid_in;
   logic [63:0]       rsp_total_ff, rsp_total_in;
   logic              rsp_fired_ff, rsp_fired_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              out_free;
   logic [SLOT_W-1:0] grant;
   logic [SLOT_W-1:0] next_live;
   logic              more_live;
   logic [SLOT_W-1:0] req_idx;
   logic              req_in_range;
   logic [4:0]        req_cap;

   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   entry_type         ram_wr_data;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_addr;
   entry_type         ram_rd_data;

   poll_req_type      poll_req;
   logic              fired;
   logic              fired_next;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_idx      = SLOT_W'(req_slot);
   assign req_in_range = (int'(req_slot) < SLOTS);
   assign req_cap      = (int'(req_max_records) > MAX_RECORDS) ? 5'(MAX_RECORDS)
                                                                : req_max_records;

   // Lowest free slot, lowest live slot at or above the scan point, and whether
   // another live slot sits above that one.
   always_comb begin
      grant     = '0;
      next_live = '0;
      more_live = 1'b0;
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (!live_ff[k]) begin
            grant = SLOT_W'(k);
         end
         if (live_ff[k] && (k >= int'(scan_ff))) begin
            next_live = SLOT_W'(k);
         end
      end
      for (int k = 0; k < SLOTS; k++) begin
         if (live_ff[k] && (k > int'(next_live))) begin
            more_live = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((op_type'(req_operation) == OP_SNAPSHOT) && (req_cap != '0)
                   && (live_ff != '0)) begin
                  state_in = ST_SNAP_ISSUE;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SNAP_ISSUE: begin
            state_in = ST_SNAP_EMIT;
         end
         ST_SNAP_EMIT: begin
            if (out_free) begin
               state_in = snap_last_ff ? ST_IDLE : ST_SNAP_ISSUE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      op_in        = op_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      full_in      = full_ff;
      seed_in      = seed_ff;
      action_in    = action_ff;
      level_in     = level_ff;
      cap_in       = cap_ff;
      nrec_in      = nrec_ff;
      scan_in      = scan_ff;
      snap_last_in = snap_last_ff;
      live_in      = live_ff;
      total_in     = total_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = req_idx;

      poll_req.strobe = 1'b0;
      poll_req.enable = wdog_en_ff;
      poll_req.limit  = stall_limit_ff;

      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_status_in       = rsp_status_ff;
      rsp_slot_id_in      = rsp_slot_id_ff;
      rsp_slot_seed_in    = rsp_slot_seed_ff;
      rsp_slot_beats_in   = rsp_slot_beats_ff;
      rsp_slot_action_in  = rsp_slot_action_ff;
      rsp_slot_level_in   = rsp_slot_level_ff;
      rsp_record_valid_in = rsp_record_valid_ff;
      rsp_total_in        = rsp_total_ff;
      rsp_fired_in        = rsp_fired_ff;
      rsp_last_in         = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_operation;
               seed_in   = req_seed;
               action_in = req_action;
               level_in  = req_level;
               cap_in    = req_cap;
               nrec_in   = '0;
               scan_in   = '0;
               full_in   = &live_ff;
               if (op_type'(req_operation) == OP_REGISTER) begin
                  idx_in = grant;
                  hit_in = 1'b0;
               end else begin
                  idx_in = req_idx;
                  hit_in = req_in_range && live_ff[req_idx];
               end
               ram_rd_en = req_in_range;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_status_in  = 1'b0;
               rsp_slot_id_in = '0;
               case (op_type'(op_ff))
                  OP_REGISTER: begin
                     if (full_ff) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        rsp_slot_id_in     = 4'(idx_ff);
                        live_in[idx_ff]    = 1'b1;
                        ram_wr_en          = 1'b1;
                        ram_wr_data.seed   = seed_ff;
                        ram_wr_data.beats  = '0;
                        ram_wr_data.action = -16'sd1;
                        ram_wr_data.level  = '0;
                     end
                  end
                  OP_BEAT: begin
                     if (hit_ff) begin
                        ram_wr_en          = 1'b1;
                        ram_wr_data.beats  = ram_rd_data.beats + 64'd1;
                        ram_wr_data.action = action_ff;
                        ram_wr_data.level  = level_ff;
                        total_in           = total_ff + 64'd1;
                     end
                  end
                  OP_UNREGISTER: begin
                     if (hit_ff) begin
                        live_in[idx_ff] = 1'b0;
                        total_in        = total_ff - ram_rd_data.beats;
                     end
                  end
                  OP_POLL: begin
                     poll_req.strobe = 1'b1;
                  end
                  default: begin
                  end
               endcase
               rsp_valid_in        = 1'b1;
               rsp_slot_seed_in    = '0;
               rsp_slot_beats_in   = '0;
               rsp_slot_action_in  = '0;
               rsp_slot_level_in   = '0;
               rsp_record_valid_in = 1'b0;
               rsp_total_in        = total_in;
               rsp_fired_in        = fired_next;
               rsp_last_in         = 1'b1;
            end
         end
         ST_SNAP_ISSUE: begin
            ram_rd_en    = 1'b1;
            ram_rd_addr  = next_live;
            idx_in       = next_live;
            scan_in      = CNT_W'(int'(next_live) + 1);
            snap_last_in = !more_live || (5'(nrec_ff + 5'd1) >= cap_ff);
         end
         ST_SNAP_EMIT: begin
            if (out_free) begin
               nrec_in             = 5'(nrec_ff + 5'd1);
               rsp_valid_in        = 1'b1;
               rsp_status_in       = 1'b0;
               rsp_slot_id_in      = 4'(idx_ff);
               rsp_slot_seed_in    = ram_rd_data.seed;
               rsp_slot_beats_in   = ram_rd_data.beats;
               rsp_slot_action_in  = ram_rd_data.action;
               rsp_slot_level_in   = ram_rd_data.level;
               rsp_record_valid_in = 1'b1;
               rsp_total_in        = total_ff;
               rsp_fired_in        = fired;
               rsp_last_in         = snap_last_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Writes land in the update step and the next read is issued no earlier than the
   // following accept, so the RAM never sees a read and write of one entry together.
   hsw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hsw_poll u_poll (
      .clock      (clock),
      .reset      (reset),
      .poll_req   (poll_req),
      .total      (total_ff),
      .fired      (fired),
      .fired_next (fired_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wdog_en_ff     <= 1'b0;
         stall_limit_ff <= 16'd2;
         live_ff        <= '0;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_WDOG_ENABLE: wdog_en_ff     <= csr_wdata[0];
               CSR_STALL_LIMIT: stall_limit_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff               <= op_in;
      idx_ff              <= idx_in;
      hit_ff              <= hit_in;
      full_ff             <= full_in;
      seed_ff             <= seed_in;
      action_ff           <= action_in;
      level_ff            <= level_in;
      cap_ff              <= cap_in;
      nrec_ff             <= nrec_in;
      scan_ff             <= scan_in;
      snap_last_ff        <= snap_last_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_slot_id_ff      <= rsp_slot_id_in;
      rsp_slot_seed_ff    <= rsp_slot_seed_in;
      rsp_slot_beats_ff   <= rsp_slot_beats_in;
      rsp_slot_action_ff  <= rsp_slot_action_in;
      rsp_slot_level_ff   <= rsp_slot_level_in;
      rsp_record_valid_ff <= rsp_record_valid_in;
      rsp_total_ff        <= rsp_total_in;
      rsp_fired_ff        <= rsp_fired_in;
      rsp_last_ff         <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_id      = rsp_slot_id_ff;
   assign rsp_slot_seed    = rsp_slot_seed_ff;
   assign rsp_slot_beats   = rsp_slot_beats_ff;
   assign rsp_slot_action  = rsp_slot_action_ff;
   assign rsp_slot_level   = rsp_slot_level_ff;
   assign rsp_record_valid = rsp_record_valid_ff;
   assign rsp_total_beats  = rsp_total_ff;
   assign rsp_stall_fired  = rsp_fired_ff;
   assign rsp_last         = rsp_last_ff;

   a_record_is_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SNAP_EMIT |-> live_ff[idx_ff])
      else $error("snapshot record taken from a free slot");

   a_record_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SNAP_ISSUE |-> nrec_ff < cap_ff)
      else $error("snapshot issued beyond its record cap");

   a_snapshot_frozen: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SNAP_ISSUE |=> $stable(total_ff) && $stable(live_ff))
      else $error("slot table changed during a snapshot");

endmodule

@@ tb/heartbeat_slot_watchdog_tb.sv @@
module heartbeat_slot_watchdog_tb import hsw_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_COUNT = 16;
   localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] OP_RESERVED_LAST = 3'd7;
   localparam int PRINT_CAP = 40;

   typedef struct {
      logic [2:0]         op;
      logic [3:0]         slot;
      logic [63:0]        seed;
      logic signed [15:0] action;
      logic [7:0]         level;
      logic [4:0]         max_rec;
   } wd_cmd_type;

   typedef struct packed {
      logic               status;
      logic [3:0]         slot_id;
      logic [63:0]        seed;
      logic [63:0]        beats;
      logic signed [15:0] action;
      logic [7:0]         level;
      logic               record_valid;
      logic [63:0]        total;
      logic               fired;
      logic               last;
   } wd_rsp_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_operation;
   logic [3:0]         req_slot;
   logic [63:0]        req_seed;
   logic signed [15:0] req_action;
   logic [7:0]         req_level;
   logic [4:0]         req_max_records;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_status;
   logic [3:0]         rsp_slot_id;
   logic [63:0]        rsp_slot_seed;
   logic [63:0]        rsp_slot_beats;
   logic signed [15:0] rsp_slot_action;
   logic [7:0]         rsp_slot_level;
   logic               rsp_record_valid;
   logic [63:0]        rsp_total_beats;
   logic               rsp_stall_fired;
   logic               rsp_last;
   logic               csr_wr_en;
   logic               csr_index;
   logic [15:0]        csr_wdata;

   // Mirror of the slot table and the watchdog.
   logic        live_slot [SLOT_COUNT];
   logic [63:0] slot_beats [SLOT_COUNT];
   logic [63:0] slot_seed [SLOT_COUNT];
   logic [15:0] slot_action [SLOT_COUNT];
   logic [7:0]  slot_level [SLOT_COUNT];
   logic [63:0] sum_live;
   logic [63:0] sum_at_last_poll;
   logic [15:0] stall_run;
   logic        fired_latch;
   logic        cfg_enable;
   logic [15:0] cfg_limit;

   wd_rsp_type awaited_rsp[$];
   int      mismatch_count = 0;
   int      next_gap = 0;
   int      ready_hold = 0;
   bit      quiet_run = 1'b0;

   heartbeat_slot_watchdog #(
      .SLOTS(SLOT_COUNT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_slot(req_slot),
      .req_seed(req_seed),
      .req_action(req_action),
      .req_level(req_level),
      .req_max_records(req_max_records),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_slot_id(rsp_slot_id),
      .rsp_slot_seed(rsp_slot_seed),
      .rsp_slot_beats(rsp_slot_beats),
      .rsp_slot_action(rsp_slot_action),
      .rsp_slot_level(rsp_slot_level),
      .rsp_record_valid(rsp_record_valid),
      .rsp_total_beats(rsp_total_beats),
      .rsp_stall_fired(rsp_stall_fired),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP) begin
         $display("%0t ERROR %s", $time, msg);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
      end
   endtask

   function automatic wd_rsp_type plain_rsp(input logic status, input logic [3:0] sid);
      wd_rsp_type r;
      r = '0;
      r.status = status;
      r.slot_id = sid;
      r.total = sum_live;
      r.fired = fired_latch;
      r.last = 1'b1;
      return r;
   endfunction

   // Applies one accepted command to the mirror and queues the results it causes.
   task automatic compute_responses(input wd_cmd_type c);
      wd_rsp_type r;
      int      i;
      int      cap;
      int      emit;
      int      n;
      logic    found;
      case (c.op)
         OP_REGISTER: begin
            found = 1'b0;
            for (i = 0; i < SLOT_COUNT; i++) begin
               if (!found && !live_slot[i]) begin
                  found = 1'b1;
                  live_slot[i] = 1'b1;
                  slot_seed[i] = c.seed;
                  slot_beats[i] = '0;
                  slot_action[i] = 16'hFFFF;
                  slot_level[i] = '0;
                  awaited_rsp.push_back(plain_rsp(1'b0, 4'(i)));
               end
            end
            if (!found) begin
               awaited_rsp.push_back(plain_rsp(1'b1, '0));
            end
         end
         OP_BEAT: begin
            if (live_slot[c.slot]) begin
               slot_action[c.slot] = c.action;
               slot_level[c.slot] = c.level;
               slot_beats[c.slot] += 64'd1;
               sum_live += 64'd1;
            end
            awaited_rsp.push_back(plain_rsp(1'b0, '0));
         end
         OP_UNREGISTER: begin
            if (live_slot[c.slot]) begin
               live_slot[c.slot] = 1'b0;
               sum_live -= slot_beats[c.slot];
            end
            awaited_rsp.push_back(plain_rsp(1'b0, '0));
         end
         OP_SNAPSHOT: begin
            cap = (c.max_rec > MAX_RECORDS) ? MAX_RECORDS : int'(c.max_rec);
            emit = 0;
            for (i = 0; i < SLOT_COUNT; i++) begin
               if (live_slot[i]) emit++;
            end
            if (emit > cap) emit = cap;
            n = 0;
            for (i = 0; i < SLOT_COUNT; i++) begin
               if (live_slot[i] && n < emit) begin
                  r = plain_rsp(1'b0, 4'(i));
                  r.seed = slot_seed[i];
                  r.beats = slot_beats[i];
                  r.action = slot_action[i];
                  r.level = slot_level[i];
                  r.record_valid = 1'b1;
                  r.last = (n == emit - 1);
                  awaited_rsp.push_back(r);
                  n++;
               end
            end
            if (emit == 0) begin
               awaited_rsp.push_back(plain_rsp(1'b0, '0));
            end
         end
         OP_POLL: begin
            if (!cfg_enable || sum_live != sum_at_last_poll) begin
               sum_at_last_poll = sum_live;
               stall_run = '0;
            end else if (sum_live != 64'd0) begin
               if (stall_run != 16'hFFFF) stall_run++;
               if (stall_run >= cfg_limit) fired_latch = 1'b1;
            end
            awaited_rsp.push_back(plain_rsp(1'b0, '0));
         end
         default: begin
            awaited_rsp.push_back(plain_rsp(1'b0, '0));
         end
      endcase
   endtask

   // Result side: compare each accepted beat, then choose the next ready value.
   always @(posedge clock) begin
      wd_rsp_type want;
      int      roll;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing pending, slot_id %0d",
                                         rsp_slot_id));
            end else begin
               want = awaited_rsp.pop_front();
               check_field("status", rsp_status, want.status);
               check_field("slot_id", rsp_slot_id, want.slot_id);
               check_field("slot_seed", rsp_slot_seed, want.seed);
               check_field("slot_beats", rsp_slot_beats, want.beats);
               check_field("slot_action", rsp_slot_action, want.action);
               check_field("slot_level", rsp_slot_level, want.level);
               check_field("record_valid", rsp_record_valid, want.record_valid);
               check_field("total_beats", rsp_total_beats, want.total);
               check_field("stall_fired", rsp_stall_fired, want.fired);
               check_field("last", rsp_last, want.last);
            end
         end
         if (quiet_run) begin
            rsp_ready <= 1'b1;
         end else if (ready_hold != 0) begin
            ready_hold--;
            rsp_ready <= 1'b0;
         end else begin
            roll = $urandom_range(99);
            if (roll < 75) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               ready_hold = (roll < 96) ? $urandom_range(2, 0) : $urandom_range(40, 10);
            end
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      if (quiet_run) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic wd_cmd_type make_cmd(input logic [2:0] op, input logic [3:0] slot);
      wd_cmd_type c;
      c.op = op;
      c.slot = slot;
      c.seed = {$urandom, $urandom};
      c.action = 16'($urandom);
      c.level = 8'($urandom);
      c.max_rec = 5'($urandom);
      return c;
   endfunction

   // Valid stays high into the next beat when the next gap is zero.
   task automatic send_item(input wd_cmd_type c);
      repeat (next_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_operation <= c.op;
      req_slot <= c.slot;
      req_seed <= c.seed;
      req_action <= c.action;
      req_level <= c.level;
      req_max_records <= c.max_rec;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      compute_responses(c);
      next_gap = pick_gap();
      if (next_gap != 0) req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      if (next_gap == 0) begin
         req_valid <= 1'b0;
         next_gap = 1;
      end
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic configure(input logic enable, input logic [15:0] limit);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WDOG_ENABLE;
      csr_wdata <= {15'd0, enable};
      @(posedge clock);
      csr_index <= CSR_STALL_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_enable = enable;
      cfg_limit = limit;
   endtask

   function automatic wd_cmd_type random_cmd(input int reg_pct, input int unreg_pct);
      wd_cmd_type c;
      int      roll;
      int      i;
      int      live_list[$];
      for (i = 0; i < SLOT_COUNT; i++) begin
         if (live_slot[i]) live_list.push_back(i);
      end
      c = make_cmd(OP_BEAT, 4'($urandom));
      roll = $urandom_range(99);
      if (roll < reg_pct) c.op = OP_REGISTER;
      else if (roll < reg_pct + unreg_pct) c.op = OP_UNREGISTER;
      else if (roll < reg_pct + unreg_pct + 12) c.op = OP_SNAPSHOT;
      else if (roll < reg_pct + unreg_pct + 32) c.op = OP_POLL;
      else if (roll < reg_pct + unreg_pct + 36) begin
         c.op = 3'($urandom_range(OP_RESERVED_LAST, OP_RESERVED_FIRST));
      end
      // Mostly address live slots so beats and releases take effect.
      if (live_list.size() != 0 && $urandom_range(99) < 85) begin
         c.slot = 4'(live_list[$urandom_range(live_list.size() - 1)]);
      end
      return c;
   endfunction

   task automatic run_random(input int count, input int reg_pct, input int unreg_pct);
      repeat (count) send_item(random_cmd(reg_pct, unreg_pct));
   endtask

   task automatic test_empty_table();
      configure(1'b1, 16'hFFFF);
      send_item(make_cmd(OP_POLL, '0));
      send_item(make_cmd(OP_SNAPSHOT, '0));
   endtask

   task automatic test_full_table();
      wd_cmd_type c;
      int      i;
      for (i = 0; i <= SLOT_COUNT; i++) begin
         c = make_cmd(OP_REGISTER, 4'($urandom));
         if (i == 0) c.seed = '0;
         if (i == 1) c.seed = '1;
         send_item(c);
      end
   endtask

   task automatic test_beat_fields();
      wd_cmd_type c;
      c = make_cmd(OP_BEAT, 4'd0);
      c.action = 16'h8000;
      c.level = 8'hFF;
      send_item(c);
      c = make_cmd(OP_BEAT, 4'd15);
      c.action = 16'h7FFF;
      c.level = 8'h00;
      send_item(c);
      send_item(make_cmd(OP_UNREGISTER, 4'd7));
      // Slot 7 is free now: neither of these may change anything.
      send_item(make_cmd(OP_BEAT, 4'd7));
      send_item(make_cmd(OP_UNREGISTER, 4'd7));
   endtask

   task automatic test_snapshot_caps();
      wd_cmd_type c;
      c = make_cmd(OP_SNAPSHOT, '0);
      c.max_rec = 5'd0;
      send_item(c);
      c.max_rec = 5'd31;
      send_item(c);
   endtask

   task automatic test_stall_counting();
      repeat (3) send_item(make_cmd(OP_POLL, 4'($urandom)));
   endtask

   task automatic test_unknown_codes();
      send_item(make_cmd(OP_RESERVED_FIRST, 4'($urandom)));
      send_item(make_cmd(OP_RESERVED_LAST, 4'($urandom)));
   endtask

   task automatic test_random_watchdog_off();
      configure(1'b0, 16'd1);
      run_random(55, 20, 12);
   endtask

   task automatic test_random_drain();
      configure(1'b1, 16'hFFFF);
      quiet_run = 1'b1;
      run_random(50, 8, 32);
      wait_idle();
      quiet_run = 1'b0;
   endtask

   task automatic test_limit_zero();
      int k;
      configure(1'b1, 16'd0);
      send_item(make_cmd(OP_REGISTER, '0));
      k = 0;
      while (!live_slot[k]) k++;
      send_item(make_cmd(OP_BEAT, 4'(k)));
      send_item(make_cmd(OP_POLL, '0));
      send_item(make_cmd(OP_POLL, '0));
   endtask

   task automatic test_random_fill();
      configure(1'b1, 16'd3);
      run_random(50, 35, 8);
   endtask

   task automatic test_random_any_limit();
      configure(1'b0, 16'($urandom));
      run_random(35, 20, 15);
   endtask

   task automatic test_random_limit_one();
      configure(1'b1, 16'd1);
      run_random(35, 20, 15);
   endtask

   initial begin
      int i;
      for (i = 0; i < SLOT_COUNT; i++) begin
         live_slot[i] = 1'b0;
         slot_beats[i] = '0;
         slot_seed[i] = '0;
         slot_action[i] = 16'hFFFF;
         slot_level[i] = '0;
      end
      sum_live = '0;
      sum_at_last_poll = '0;
      stall_run = '0;
      fired_latch = 1'b0;
      cfg_enable = 1'b0;
      cfg_limit = 16'd2;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_POLL;
      req_slot <= '0;
      req_seed <= '0;
      req_action <= '0;
      req_level <= '0;
      req_max_records <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_WDOG_ENABLE;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_full_table();
      test_beat_fields();
      test_snapshot_caps();
      test_stall_counting();
      test_unknown_codes();
      test_random_watchdog_off();
      test_random_drain();
      test_limit_zero();
      test_random_fill();
      test_random_any_limit();
      test_random_limit_one();

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/hsw_pkg.sv
rtl/hsw_ram.sv
rtl/hsw_poll.sv
rtl/heartbeat_slot_watchdog.sv
tb/heartbeat_slot_watchdog_tb.sv
